// File: design/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg
// shared types and constants of the probabilistic bloom filter
// ----------------------------------------------------------------------------
package pbf_pkg;

	// fixed field widths
	localparam int HASH_W     = 32;
	localparam int HIT_W      = 5;
	localparam int NH_W       = 5;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int DRAW_W     = 16;
	localparam int LFSR_W     = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INSERT_THRESHOLD = 2'd2;

	// register reset values
	localparam logic [NH_W-1:0]       NUM_HASHES_RST       = 5'd4;
	localparam logic [CFG_DATA_W-1:0] FILTER_SIZE_RST      = 17'd65536;
	localparam logic [CFG_DATA_W-1:0] INSERT_THRESHOLD_RST = 17'd32768;

	// item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// galois lfsr for the insert draws
	localparam logic [LFSR_W-1:0] LFSR_SEED = 32'hACE1_ACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hD000_0001;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_SETUP,
		B_ROUND,
		B_DRAIN
	} back_state_t;

endpackage

// File: design/pbf_ram.sv
// ----------------------------------------------------------------------------
// pbf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pbf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: design/pbf_mod_unit.sv
// ----------------------------------------------------------------------------
// pbf_mod_unit
// restoring remainder of a hash word by the filter size, one bit a cycle
// ----------------------------------------------------------------------------
module pbf_mod_unit #(
	parameter int AW = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pbf_pkg::HASH_W-1:0] dividend,
	input  logic [AW:0]               modulus,
	output logic                      busy,
	output logic [AW-1:0]             remainder
);

	localparam int CNT_W = $clog2(pbf_pkg::HASH_W);

	logic                       busy_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [pbf_pkg::HASH_W-1:0] div_q;
	logic [AW-1:0]              rem_q;
	logic [AW:0]                trial;
	logic [AW:0]                diff;
	logic [AW-1:0]              rem_next;

	// one restoring step
	always_comb begin
		trial    = {rem_q, div_q[pbf_pkg::HASH_W-1]};
		diff     = trial - modulus;
		rem_next = (trial >= modulus) ? diff[AW-1:0] : trial[AW-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(pbf_pkg::HASH_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend shifter and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= div_q << 1;
			rem_q <= rem_next;
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

// File: design/pbf_front.sv
// ----------------------------------------------------------------------------
// pbf_front
// accepts items and reduces both hashes by the filter size
// ----------------------------------------------------------------------------
module pbf_front #(
	parameter int AW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       kind,
	input  logic [pbf_pkg::HASH_W-1:0] hash_a,
	input  logic [pbf_pkg::HASH_W-1:0] hash_b,
	input  logic [AW:0]                m_eff,
	input  logic                       store_ready,
	output logic                       q_push,
	input  logic                       q_full,
	output logic [2*AW:0]              q_data
);

	pbf_pkg::front_state_t state_q, state_d;

	logic          start;
	logic          busy_a;
	logic          busy_b;
	logic          kind_q;
	logic [AW-1:0] rem_a;
	logic [AW-1:0] rem_b;

	// remainder units, one per hash
	pbf_mod_unit #(.AW(AW)) u_mod_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.dividend  (hash_a),
		.modulus   (m_eff),
		.busy      (busy_a),
		.remainder (rem_a)
	);

	pbf_mod_unit #(.AW(AW)) u_mod_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.dividend  (hash_b),
		.modulus   (m_eff),
		.busy      (busy_b),
		.remainder (rem_b)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pbf_pkg::F_IDLE: begin
				if (start) begin
					state_d = pbf_pkg::F_CALC;
				end
			end
			pbf_pkg::F_CALC: begin
				if (!busy_a && !busy_b) begin
					state_d = pbf_pkg::F_PUSH;
				end
			end
			pbf_pkg::F_PUSH: begin
				if (!q_full) begin
					state_d = pbf_pkg::F_IDLE;
				end
			end
			default: state_d = pbf_pkg::F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		full   = (state_q != pbf_pkg::F_IDLE) || !store_ready;
		start  = push && !full;
		q_push = (state_q == pbf_pkg::F_PUSH);
		q_data = {kind_q, rem_a, rem_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbf_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item kind held alongside the reduction
	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= kind;
		end
	end

endmodule

// File: design/pbf_queue.sv
// ----------------------------------------------------------------------------
// pbf_queue
// short register queue between the front and the back
// ----------------------------------------------------------------------------
module pbf_queue #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop_ok) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// File: design/pbf_back.sv
// ----------------------------------------------------------------------------
// pbf_back
// runs the hash rounds against the bit store and holds the query result
// ----------------------------------------------------------------------------
module pbf_back #(
	parameter int AW       = 16,
	parameter int KW       = 5,
	parameter int MAX_BITS = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          store_ready,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic [2*AW:0]                 q_data,
	input  logic [AW:0]                   m_eff,
	input  logic [KW-1:0]                 k_eff,
	input  logic [pbf_pkg::CFG_DATA_W-1:0] threshold,
	output logic                          empty,
	input  logic                          pop,
	output logic [pbf_pkg::HIT_W-1:0]     hit_count
);

	pbf_pkg::back_state_t state_q, state_d;

	logic [AW-1:0]                clr_q;
	logic                         kind_q;
	logic [AW-1:0]                first_q;
	logic [AW-1:0]                second_q;
	logic [AW-1:0]                s2_q;
	logic [AW-1:0]                t_q;
	logic [AW-1:0]                d_q;
	logic [KW-1:0]                y_q;
	logic [pbf_pkg::HIT_W-1:0]    hits_q;
	logic                         rd_s1;
	logic [pbf_pkg::LFSR_W-1:0]   lfsr_q;
	logic [pbf_pkg::LFSR_W-1:0]   lfsr_next;
	logic                         res_valid_q;
	logic [pbf_pkg::HIT_W-1:0]    res_q;

	logic                         head_kind;
	logic                         can_start;
	logic                         rounds_done;
	logic                         active;
	logic [AW-1:0]                idx;
	logic                         draw_hit;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic                         ram_wdata;
	logic                         ram_rdata;

	// sum of two residues, brought back below the modulus
	function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] x, input logic [AW-1:0] y,
			input logic [AW:0] m);
		logic [AW:0] sum;
		logic [AW:0] diff;
		sum  = {1'b0, x} + {1'b0, y};
		diff = sum - m;
		return (sum >= m) ? diff[AW-1:0] : sum[AW-1:0];
	endfunction

	// bit store
	pbf_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	// round index and random draw
	always_comb begin
		head_kind   = q_data[2*AW];
		can_start   = !q_empty && (head_kind == pbf_pkg::KIND_INSERT || !res_valid_q);
		rounds_done = (y_q == k_eff);
		active      = (state_q == pbf_pkg::B_ROUND) && !rounds_done;
		idx         = add_mod(first_q, t_q, m_eff);
		lfsr_next   = {1'b0, lfsr_q[pbf_pkg::LFSR_W-1:1]}
			^ (lfsr_q[0] ? pbf_pkg::LFSR_TAPS : '0);
		draw_hit    = {1'b0, lfsr_next[pbf_pkg::DRAW_W-1:0]} < threshold;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pbf_pkg::B_CLEAR: begin
				if (clr_q == AW'(MAX_BITS - 1)) begin
					state_d = pbf_pkg::B_IDLE;
				end
			end
			pbf_pkg::B_IDLE: begin
				if (can_start) begin
					state_d = pbf_pkg::B_SETUP;
				end
			end
			pbf_pkg::B_SETUP: begin
				state_d = pbf_pkg::B_ROUND;
			end
			pbf_pkg::B_ROUND: begin
				if (rounds_done) begin
					state_d = (kind_q == pbf_pkg::KIND_QUERY) ? pbf_pkg::B_DRAIN
						: pbf_pkg::B_IDLE;
				end
			end
			pbf_pkg::B_DRAIN: begin
				state_d = pbf_pkg::B_IDLE;
			end
			default: state_d = pbf_pkg::B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		store_ready = (state_q != pbf_pkg::B_CLEAR);
		q_pop       = (state_q == pbf_pkg::B_IDLE) && can_start;
		ram_we      = 1'b0;
		ram_waddr   = idx;
		ram_wdata   = 1'b1;
		case (state_q)
			pbf_pkg::B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 1'b0;
			end
			pbf_pkg::B_ROUND: begin
				ram_we = active && (kind_q == pbf_pkg::KIND_INSERT) && draw_hit;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbf_pkg::B_CLEAR;
			clr_q       <= '0;
			lfsr_q      <= pbf_pkg::LFSR_SEED;
			rd_s1       <= 1'b0;
			y_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= active && (kind_q == pbf_pkg::KIND_QUERY);
			if (state_q == pbf_pkg::B_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == pbf_pkg::B_SETUP) begin
				y_q <= '0;
			end else if (active) begin
				y_q <= y_q + KW'(1);
			end
			if (active && kind_q == pbf_pkg::KIND_INSERT) begin
				lfsr_q <= lfsr_next;
			end
			if (state_q == pbf_pkg::B_DRAIN) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// round datapath: t steps through y*y*b, d through (2y+1)*b, both mod m
	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q   <= head_kind;
			first_q  <= q_data[2*AW-1:AW];
			second_q <= q_data[AW-1:0];
		end
		if (state_q == pbf_pkg::B_SETUP) begin
			s2_q   <= add_mod(second_q, second_q, m_eff);
			d_q    <= second_q;
			t_q    <= '0;
			hits_q <= '0;
		end else begin
			if (active) begin
				t_q <= add_mod(t_q, d_q, m_eff);
				d_q <= add_mod(d_q, s2_q, m_eff);
			end
			if (rd_s1) begin
				hits_q <= hits_q + pbf_pkg::HIT_W'(ram_rdata);
			end
		end
		if (state_q == pbf_pkg::B_DRAIN) begin
			res_q <= hits_q;
		end
	end

	assign empty     = !res_valid_q;
	assign hit_count = res_q;

endmodule

// File: design/probabilistic_bloom_filter_top.sv
// ----------------------------------------------------------------------------
// probabilistic_bloom_filter_top
// bloom filter with double hashing and probabilistic insert over a bit store
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          kind, hash_a, hash_b
//  result    empty / pop          hit_count (one per query, none per insert)
//  config    cfg_we               cfg_index, cfg_data
//
//  the front takes one item at a time and reduces it in the two 32-step
//  remainder units; the back then runs k_eff rounds an item, one bit store
//  read per query round and a write only on an insert round's random hit.
//  after reset a clearing pass over all MAX_BITS entries holds full high.
//  a two-item queue parts front and back; a waiting result stalls a query
//  at its head and all behind it; the front accepts until that queue fills.
// ----------------------------------------------------------------------------
module probabilistic_bloom_filter_top #(
	parameter int MAX_BITS   = 65536,
	parameter int MAX_HASHES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           kind,
	input  logic [pbf_pkg::HASH_W-1:0]     hash_a,
	input  logic [pbf_pkg::HASH_W-1:0]     hash_b,
	output logic                           empty,
	input  logic                           pop,
	output logic [pbf_pkg::HIT_W-1:0]      hit_count,
	input  logic                           cfg_we,
	input  logic [pbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbf_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_BITS);
	localparam int MW = AW + 1;
	localparam int KW = $clog2(MAX_HASHES + 1);
	localparam int CW = (MW > pbf_pkg::CFG_DATA_W) ? MW : pbf_pkg::CFG_DATA_W;
	localparam int HW = (KW > pbf_pkg::NH_W) ? KW : pbf_pkg::NH_W;

	logic [pbf_pkg::NH_W-1:0]       num_hashes_q;
	logic [pbf_pkg::CFG_DATA_W-1:0] filter_size_q;
	logic [pbf_pkg::CFG_DATA_W-1:0] insert_threshold_q;
	logic [CW-1:0]                  fs_wide;
	logic [HW-1:0]                  nh_wide;
	logic [MW-1:0]                  m_eff;
	logic [KW-1:0]                  k_eff;
	logic                           store_ready;
	logic                           fq_push;
	logic                           fq_full;
	logic [2*AW:0]                  fq_wdata;
	logic                           fq_pop;
	logic                           fq_empty;
	logic [2*AW:0]                  fq_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_hashes_q       <= pbf_pkg::NUM_HASHES_RST;
			filter_size_q      <= pbf_pkg::FILTER_SIZE_RST;
			insert_threshold_q <= pbf_pkg::INSERT_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pbf_pkg::CFG_NUM_HASHES:       num_hashes_q <= cfg_data[pbf_pkg::NH_W-1:0];
				pbf_pkg::CFG_FILTER_SIZE:      filter_size_q <= cfg_data;
				pbf_pkg::CFG_INSERT_THRESHOLD: insert_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective modulus and round count
	always_comb begin
		fs_wide = CW'(filter_size_q);
		nh_wide = HW'(num_hashes_q);
		if (fs_wide == '0) begin
			m_eff = MW'(1);
		end else if (fs_wide > CW'(MAX_BITS)) begin
			m_eff = MW'(MAX_BITS);
		end else begin
			m_eff = fs_wide[MW-1:0];
		end
		if (nh_wide > HW'(MAX_HASHES)) begin
			k_eff = KW'(MAX_HASHES);
		end else begin
			k_eff = nh_wide[KW-1:0];
		end
	end

	pbf_front #(.AW(AW)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.hash_a      (hash_a),
		.hash_b      (hash_b),
		.m_eff       (m_eff),
		.store_ready (store_ready),
		.q_push      (fq_push),
		.q_full      (fq_full),
		.q_data      (fq_wdata)
	);

	pbf_queue #(.WIDTH(2 * AW + 1), .DEPTH(2)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (fq_full),
		.wdata  (fq_wdata),
		.pop    (fq_pop),
		.empty  (fq_empty),
		.rdata  (fq_rdata)
	);

	pbf_back #(.AW(AW), .KW(KW), .MAX_BITS(MAX_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.store_ready (store_ready),
		.q_empty     (fq_empty),
		.q_pop       (fq_pop),
		.q_data      (fq_rdata),
		.m_eff       (m_eff),
		.k_eff       (k_eff),
		.threshold   (insert_threshold_q),
		.empty       (empty),
		.pop         (pop),
		.hit_count   (hit_count)
	);

endmodule
